>>> hw/rtl/ipv4hcf_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 length and checksum fixup package
// Types, constants and the output byte selection shared by the fixup core.
// ----------------------------------------------------------------------------
package ipv4hcf_pkg;

    localparam int HOLD_DEPTH  = 10;
    localparam int LINE_DEPTH  = HOLD_DEPTH + 1;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_FRAME      = 16'd34;
    localparam logic [15:0] POS_LAST_HDR   = 16'd33;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_CSUM_FIRST = 16'd15;
    localparam logic [15:0] POS_LEN_HI     = 16'd16;
    localparam logic [15:0] POS_LEN_LO     = 16'd17;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_CKS_HI     = 16'd24;
    localparam logic [15:0] POS_CKS_LO     = 16'd25;
    localparam logic [15:0] POS_MAX        = 16'hffff;

    localparam logic [7:0]  ETYPE_HI       = 8'h08;
    localparam logic [7:0]  ETYPE_LO       = 8'h00;
    localparam logic [7:0]  PROTO_ICMP     = 8'h01;
    localparam logic [15:0] CSUM_INIT      = 16'hffff;
    localparam logic [16:0] CSUM_FOLD      = 17'h0ffff;

    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_LEN    = 2'd1;
    localparam logic [1:0] KIND_CKS_HI = 2'd2;
    localparam logic [1:0] KIND_CKS_LO = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] alt;
        logic [1:0] kind;
    } t_hold_entry;

    typedef struct packed {
        logic        rw;
        logic        hdr_done;
        logic [15:0] cks;
    } t_snap;

    typedef struct packed {
        t_hold_entry hold;
        logic        last;
        t_snap       snap;
    } t_q_entry;

    function automatic logic [7:0] emit_byte(t_hold_entry e, t_snap s);
        logic [7:0] res;
        res = e.data;
        unique case (e.kind)
            KIND_PLAIN:  res = e.data;
            KIND_LEN:    if (s.rw) res = e.alt;
            KIND_CKS_HI: if (s.rw && s.hdr_done) res = s.cks[15:8];
            KIND_CKS_LO: if (s.rw && s.hdr_done) res = s.cks[7:0];
            default:     res = e.data;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/ipv4hcf_front.sv
// ----------------------------------------------------------------------------
// IPv4 fixup front end
// Tracks the byte position, matches the header fields, accumulates the
// header checksum and tags each incoming word for the back end.
// ----------------------------------------------------------------------------
module ipv4hcf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_data_byte,
    input  logic [15:0]           i_frame_length,
    input  logic                  i_last_byte,
    input  logic                  i_q_space,
    output logic                  o_push,
    output ipv4hcf_pkg::t_q_entry o_entry
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [1:0]  r_flags, n_flags;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_hi, n_hi;

    logic [15:0] new_len;
    logic [15:0] word;
    logic [16:0] sum;

    assign o_ready = i_q_space;
    assign o_push  = i_valid && i_q_space;

    always_comb begin
        n_len   = (r_pos == 16'd0) ? i_frame_length : r_len;
        new_len = n_len - ipv4hcf_pkg::ETH_HDR_LEN;
        n_flags = r_flags;
        n_acc   = r_acc;
        n_hi    = r_hi;
        word    = {r_hi, i_data_byte};
        sum     = '0;
        if (r_pos < ipv4hcf_pkg::MIN_FRAME) begin
            if (!r_pos[0]) begin
                n_hi = i_data_byte;
            end else begin
                if (r_pos == ipv4hcf_pkg::POS_ETYPE_LO && r_hi == ipv4hcf_pkg::ETYPE_HI
                        && i_data_byte == ipv4hcf_pkg::ETYPE_LO) begin
                    n_flags[0] = 1'b1;
                end
                if (r_pos >= ipv4hcf_pkg::POS_CSUM_FIRST) begin
                    if (r_pos == ipv4hcf_pkg::POS_LEN_LO) begin
                        word = new_len;
                    end else if (r_pos == ipv4hcf_pkg::POS_CKS_LO) begin
                        word = 16'd0;
                    end
                    sum = {1'b0, r_acc} + {1'b0, word};
                    if (sum > ipv4hcf_pkg::CSUM_FOLD) begin
                        sum = sum - ipv4hcf_pkg::CSUM_FOLD;
                    end
                    n_acc = sum[15:0];
                end
            end
            if (r_pos == ipv4hcf_pkg::POS_PROTO && i_data_byte == ipv4hcf_pkg::PROTO_ICMP) begin
                n_flags[1] = 1'b1;
            end
        end
        n_pos = (r_pos == ipv4hcf_pkg::POS_MAX) ? r_pos : r_pos + 16'd1;

        o_entry.hold.data = i_data_byte;
        o_entry.hold.alt  = 8'd0;
        o_entry.hold.kind = ipv4hcf_pkg::KIND_PLAIN;
        if (r_pos == ipv4hcf_pkg::POS_LEN_HI) begin
            o_entry.hold.kind = ipv4hcf_pkg::KIND_LEN;
            o_entry.hold.alt  = new_len[15:8];
        end else if (r_pos == ipv4hcf_pkg::POS_LEN_LO) begin
            o_entry.hold.kind = ipv4hcf_pkg::KIND_LEN;
            o_entry.hold.alt  = new_len[7:0];
        end else if (r_pos == ipv4hcf_pkg::POS_CKS_HI) begin
            o_entry.hold.kind = ipv4hcf_pkg::KIND_CKS_HI;
        end else if (r_pos == ipv4hcf_pkg::POS_CKS_LO) begin
            o_entry.hold.kind = ipv4hcf_pkg::KIND_CKS_LO;
        end
        o_entry.last          = i_last_byte;
        o_entry.snap.rw       = (n_flags == 2'b11) && (n_len >= ipv4hcf_pkg::MIN_FRAME);
        o_entry.snap.hdr_done = r_pos >= ipv4hcf_pkg::POS_LAST_HDR;
        o_entry.snap.cks      = ~n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_flags <= '0;
            r_acc   <= ipv4hcf_pkg::CSUM_INIT;
            r_hi    <= '0;
        end else if (o_push) begin
            r_len <= n_len;
            if (i_last_byte) begin
                r_pos   <= '0;
                r_flags <= '0;
                r_acc   <= ipv4hcf_pkg::CSUM_INIT;
                r_hi    <= '0;
            end else begin
                r_pos   <= n_pos;
                r_flags <= n_flags;
                r_acc   <= n_acc;
                r_hi    <= n_hi;
            end
        end
    end

endmodule

>>> hw/rtl/ipv4hcf_queue.sv
// ----------------------------------------------------------------------------
// IPv4 fixup queue
// Short first-in first-out buffer of tagged words between front and back end.
// ----------------------------------------------------------------------------
module ipv4hcf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipv4hcf_pkg::t_q_entry i_entry,
    output logic                  o_space,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ipv4hcf_pkg::t_q_entry o_entry
);

    ipv4hcf_pkg::t_q_entry r_mem [ipv4hcf_pkg::QUEUE_DEPTH];
    logic [ipv4hcf_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [ipv4hcf_pkg::QUEUE_CW-1:0] r_cnt;

    assign o_space = r_cnt != ipv4hcf_pkg::QUEUE_CW'(ipv4hcf_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == ipv4hcf_pkg::QUEUE_AW'(ipv4hcf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == ipv4hcf_pkg::QUEUE_AW'(ipv4hcf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ipv4hcf_back.sv
// ----------------------------------------------------------------------------
// IPv4 fixup back end
// Ten-word delay line with end-of-frame drain, byte rewrite and output
// register.
// ----------------------------------------------------------------------------
module ipv4hcf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ipv4hcf_pkg::t_q_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    output logic                  o_rewritten
);

    ipv4hcf_pkg::t_hold_entry r_line [ipv4hcf_pkg::LINE_DEPTH];
    logic [ipv4hcf_pkg::LINE_AW-1:0] r_cnt;
    logic                            r_flush;
    ipv4hcf_pkg::t_snap              r_snap;

    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_orw;

    logic                            slot_free;
    logic                            need_out;
    logic                            flush_emit;
    logic                            emit;
    logic                            shift;
    logic                            final_word;
    logic [ipv4hcf_pkg::LINE_AW-1:0] wr_idx;
    ipv4hcf_pkg::t_snap              snap_sel;

    assign slot_free  = !r_ovalid || i_ready;
    assign need_out   = !i_q_entry.last
                        && (r_cnt == ipv4hcf_pkg::LINE_AW'(ipv4hcf_pkg::HOLD_DEPTH));
    assign o_q_pop    = i_q_valid && !r_flush && (!need_out || slot_free);
    assign flush_emit = r_flush && slot_free;
    assign emit       = (o_q_pop && need_out) || flush_emit;
    assign shift      = emit;
    assign final_word = flush_emit && (r_cnt == ipv4hcf_pkg::LINE_AW'(1));
    assign wr_idx     = need_out ? ipv4hcf_pkg::LINE_AW'(ipv4hcf_pkg::HOLD_DEPTH - 1) : r_cnt;
    assign snap_sel   = r_flush ? r_snap : i_q_entry.snap;

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;
    assign o_rewritten = r_orw;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ipv4hcf_pkg::LINE_DEPTH; i++) begin
            if (o_q_pop && wr_idx == ipv4hcf_pkg::LINE_AW'(i)) begin
                r_line[i] <= i_q_entry.hold;
            end else if (shift && i < ipv4hcf_pkg::LINE_DEPTH - 1) begin
                r_line[i] <= r_line[(i + 1) % ipv4hcf_pkg::LINE_DEPTH];
            end
        end
        if (o_q_pop && i_q_entry.last) begin
            r_snap <= i_q_entry.snap;
        end
        if (slot_free && emit) begin
            r_obyte <= ipv4hcf_pkg::emit_byte(r_line[0], snap_sel);
            r_olast <= final_word;
            r_orw   <= final_word && r_snap.rw && r_snap.hdr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (slot_free) begin
                r_ovalid <= emit;
            end
            if (o_q_pop) begin
                if (!need_out) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_q_entry.last) begin
                    r_flush <= 1'b1;
                end
            end else if (flush_emit) begin
                r_cnt <= r_cnt - 1'b1;
                if (final_word) begin
                    r_flush <= 1'b0;
                end
            end
        end
    end

endmodule

>>> hw/rtl/ipv4_header_length_checksum_fixup_core.sv
// ----------------------------------------------------------------------------
// IPv4 header length and checksum fixup core
// Rewrites the IPv4 total length and header checksum of ICMP frames in a
// byte stream.
// ----------------------------------------------------------------------------
// One word is taken per cycle while the frame streams and the output is not
// stalled; each output word leaves ten input words after it arrived, so a
// frame's checksum can be put in place. When the last word of a frame is
// taken, the back end drains its held words, up to eleven, one per cycle
// while the output accepts them, and takes no new words from the two-entry
// queue until the drain is done; input keeps flowing until that queue is
// full. Sustained rate is one word per cycle in a frame, gapped at frame end.
module ipv4_header_length_checksum_fixup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_frame_length,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_rewritten
);

    logic                  push;
    logic                  q_space;
    logic                  q_valid;
    logic                  q_pop;
    ipv4hcf_pkg::t_q_entry push_entry;
    ipv4hcf_pkg::t_q_entry head_entry;

    ipv4hcf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_frame_length (i_frame_length),
        .i_last_byte    (i_last_byte),
        .i_q_space      (q_space),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    ipv4hcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    ipv4hcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_rewritten (o_rewritten)
    );

endmodule
